// ===== rtl/core/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types and constants of the integer matrix multiply block: field
// widths, op and register codes, the queue entry and the back-end states.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int MAX_DIM_DEF   = 16;
  localparam int ELEM_BITS_DEF = 16;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 4;
  localparam int VAL_W   = 16;
  localparam int OUT_W   = 37;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_WR_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_B = 2'd1;
  localparam logic [OP_W-1:0] OP_CALC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd1;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;

  typedef enum logic [1:0] {
    KIND_WR_A,
    KIND_WR_B,
    KIND_CALC,
    KIND_ERR
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } q_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN
  } back_state_t;

endpackage

// ===== rtl/core/imm_front.sv =====
// ----------------------------------------------------------------------------
// imm_front
// Holds the size registers, takes input items and sorts them into store
// writes, dot product jobs and out-of-range answers for the job queue;
// store writes with an out-of-range index are dropped.
module imm_front #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [imm_pkg::OP_W-1:0]     in_op,
  input  logic [imm_pkg::IDX_W-1:0]    in_row_index,
  input  logic [imm_pkg::IDX_W-1:0]    in_col_index,
  input  logic [imm_pkg::VAL_W-1:0]    in_elem_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [imm_pkg::CFG_W-1:0]    cfg_data,
  output logic [imm_pkg::CFG_W-1:0]    inner_dim_cfg,
  input  logic                         q_full,
  output logic                         q_push,
  output imm_pkg::q_entry_t            q_push_entry
);

  import imm_pkg::*;

  localparam int CW = ($clog2(MAX_DIM + 1) > CFG_W) ? $clog2(MAX_DIM + 1) : CFG_W;
  localparam logic [CW-1:0] LIM = CW'(MAX_DIM);

  logic [CFG_W-1:0] rows_a_r, rows_a_nxt;
  logic [CFG_W-1:0] inner_dim_r, inner_dim_nxt;
  logic [CFG_W-1:0] cols_b_r, cols_b_nxt;

  logic [CW-1:0] nr, nc, row_x, col_x;
  logic          keep;
  job_kind_t     kind;

  function automatic logic [CW-1:0] sat_size(input logic [CFG_W-1:0] reg_val);
    logic [CW-1:0] v;
    v = CW'(reg_val);
    return (v > LIM) ? LIM : v;
  endfunction

  assign cfg_ready     = 1'b1;
  assign inner_dim_cfg = inner_dim_r;

  always_comb begin
    rows_a_nxt    = rows_a_r;
    inner_dim_nxt = inner_dim_r;
    cols_b_nxt    = cols_b_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROWS_A:    rows_a_nxt    = cfg_data;
        CFG_INNER_DIM: inner_dim_nxt = cfg_data;
        CFG_COLS_B:    cols_b_nxt    = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= CFG_RESET;
      inner_dim_r <= CFG_RESET;
      cols_b_r    <= CFG_RESET;
    end else begin
      rows_a_r    <= rows_a_nxt;
      inner_dim_r <= inner_dim_nxt;
      cols_b_r    <= cols_b_nxt;
    end
  end

  always_comb begin
    nr    = sat_size(rows_a_r);
    nc    = sat_size(cols_b_r);
    row_x = CW'(in_row_index);
    col_x = CW'(in_col_index);
    keep  = 1'b0;
    kind  = KIND_ERR;
    unique case (in_op)
      OP_WR_A: begin
        keep = (row_x < LIM) && (col_x < LIM);
        kind = KIND_WR_A;
      end
      OP_WR_B: begin
        keep = (row_x < LIM) && (col_x < LIM);
        kind = KIND_WR_B;
      end
      OP_CALC: begin
        keep = 1'b1;
        kind = ((row_x >= nr) || (col_x >= nc)) ? KIND_ERR : KIND_CALC;
      end
      default: ;
    endcase
  end

  assign in_stall           = q_full;
  assign q_push             = in_valid && !in_stall && keep;
  assign q_push_entry.kind  = kind;
  assign q_push_entry.row   = in_row_index;
  assign q_push_entry.col   = in_col_index;
  assign q_push_entry.value = in_elem_value;

endmodule

// ===== rtl/core/imm_queue.sv =====
// ----------------------------------------------------------------------------
// imm_queue
// Short first-in first-out job queue between the front and back ends.
// ----------------------------------------------------------------------------
module imm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  imm_pkg::q_entry_t push_entry,
  output logic              full,
  output logic              not_empty,
  input  logic              pop,
  output imm_pkg::q_entry_t pop_entry
);

  import imm_pkg::*;

  q_entry_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]     count_r, count_nxt;

  assign full      = (count_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/imm_back.sv =====
// ----------------------------------------------------------------------------
// imm_back
// Executes queued jobs: writes the A and B element memories and runs the
// dot product through one pipelined multiply-accumulate, then holds the
// result, or a range error, in the output register.
// ----------------------------------------------------------------------------
module imm_back #(
  parameter int MAX_DIM   = imm_pkg::MAX_DIM_DEF,
  parameter int ELEM_BITS = imm_pkg::ELEM_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_not_empty,
  input  imm_pkg::q_entry_t          q_entry,
  output logic                       q_pop,
  input  logic [imm_pkg::CFG_W-1:0]  inner_dim_cfg,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [imm_pkg::OUT_W-1:0]  out_product_value,
  output logic                       out_range_error
);

  import imm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int KW     = $clog2(MAX_DIM);
  localparam int PROD_W = 2 * ELEM_BITS;
  localparam int CW = ($clog2(MAX_DIM + 1) > CFG_W) ? $clog2(MAX_DIM + 1) : CFG_W;
  localparam logic [CW-1:0] LIM = CW'(MAX_DIM);
  localparam logic [AW-1:0] STRIDE = AW'(MAX_DIM);

  logic [ELEM_BITS-1:0] a_mem [DEPTH];
  logic [ELEM_BITS-1:0] b_mem [DEPTH];

  back_state_t state_r, state_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [CW-1:0]    nk_r, nk_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic             rd_v_r, mul_v_r;
  logic             rd_en, we_a, we_b;

  logic signed [ELEM_BITS-1:0] a_rd_r, b_rd_r;
  logic signed [PROD_W-1:0]    prod_r, prod_nxt;
  logic signed [OUT_W-1:0]     acc_r, acc_nxt;
  logic                        acc_clr;

  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_prod_r, out_prod_nxt;
  logic             out_err_r, out_err_nxt;
  logic             out_free, out_load;

  logic [CW-1:0]        nk_cfg;
  logic [AW-1:0]        wr_addr, a_raddr, b_raddr;
  logic [ELEM_BITS-1:0] wr_data;

  always_comb begin
    nk_cfg  = (CW'(inner_dim_cfg) > LIM) ? LIM : CW'(inner_dim_cfg);
    wr_addr = AW'(q_entry.row) * STRIDE + AW'(q_entry.col);
    wr_data = ELEM_BITS'($unsigned(q_entry.value));
    a_raddr = AW'(row_r) * STRIDE + AW'(k_r);
    b_raddr = AW'(k_r) * STRIDE + AW'(col_r);
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    nk_nxt       = nk_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    q_pop        = 1'b0;
    we_a         = 1'b0;
    we_b         = 1'b0;
    rd_en        = 1'b0;
    acc_clr      = 1'b0;
    out_load     = 1'b0;
    out_prod_nxt = out_prod_r;
    out_err_nxt  = out_err_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_not_empty) begin
          unique case (q_entry.kind)
            KIND_WR_A: begin
              q_pop = 1'b1;
              we_a  = 1'b1;
            end
            KIND_WR_B: begin
              q_pop = 1'b1;
              we_b  = 1'b1;
            end
            KIND_ERR: begin
              if (out_free) begin
                q_pop        = 1'b1;
                out_load     = 1'b1;
                out_prod_nxt = '0;
                out_err_nxt  = 1'b1;
              end
            end
            KIND_CALC: begin
              q_pop   = 1'b1;
              acc_clr = 1'b1;
              row_nxt = q_entry.row;
              col_nxt = q_entry.col;
              nk_nxt  = nk_cfg;
              k_nxt   = '0;
              state_nxt = (nk_cfg == '0) ? BK_DRAIN : BK_RUN;
            end
          endcase
        end
      end
      BK_RUN: begin
        rd_en = 1'b1;
        if (CW'(k_r) == nk_r - 1'b1) begin
          state_nxt = BK_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      BK_DRAIN: begin
        if (!rd_v_r && !mul_v_r && out_free) begin
          out_load     = 1'b1;
          out_prod_nxt = acc_r;
          out_err_nxt  = 1'b0;
          state_nxt    = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    prod_nxt = a_rd_r * b_rd_r;
    priority if (acc_clr) begin
      acc_nxt = '0;
    end else if (mul_v_r) begin
      acc_nxt = acc_r + OUT_W'(prod_r);
    end else begin
      acc_nxt = acc_r;
    end
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= rd_en;
      mul_v_r     <= rd_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    nk_r       <= nk_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    out_prod_r <= out_prod_nxt;
    out_err_r  <= out_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      a_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      a_rd_r <= a_mem[a_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      b_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      b_rd_r <= b_mem[b_raddr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_product_value = out_prod_r;
  assign out_range_error   = out_err_r;

endmodule

// ===== rtl/core/integer_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Dense integer matrix product, one element of C = A x B per request.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  op, row_index, col_index, elem_value
//   out      output     out_valid/out_stall product_value, range_error
//   cfg      input      cfg_valid/cfg_ready index, data (rows_a, inner_dim, cols_b)
//
// a store write is done in the back-end idle state; an out-of-range request
// waits there for a free output register; a compute request walks the
// saturated inner_dim (none when it is zero) through the single
// multiply-accumulate (read, multiply, add)
// synchronous active-low reset sets all sizes to 1; element memories are
// not cleared; a two-entry job queue lets input transfers continue while
// the back end computes or the output register waits on out_stall
// ----------------------------------------------------------------------------
module integer_matrix_multiply #(
  parameter int MAX_DIM   = imm_pkg::MAX_DIM_DEF,
  parameter int ELEM_BITS = imm_pkg::ELEM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [imm_pkg::OP_W-1:0]      in_op,
  input  logic [imm_pkg::IDX_W-1:0]     in_row_index,
  input  logic [imm_pkg::IDX_W-1:0]     in_col_index,
  input  logic signed [imm_pkg::VAL_W-1:0] in_elem_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [imm_pkg::OUT_W-1:0] out_product_value,
  output logic                          out_range_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [imm_pkg::CFG_W-1:0]     cfg_data
);

  import imm_pkg::*;

  logic             q_full, q_push, q_not_empty, q_pop;
  q_entry_t         q_push_entry, q_pop_entry;
  logic [CFG_W-1:0] inner_dim_cfg;
  logic [OUT_W-1:0] product_raw;

  imm_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_elem_value(in_elem_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .inner_dim_cfg(inner_dim_cfg),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_push_entry (q_push_entry)
  );

  imm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_push_entry),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_entry (q_pop_entry)
  );

  imm_back #(
    .MAX_DIM  (MAX_DIM),
    .ELEM_BITS(ELEM_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_entry          (q_pop_entry),
    .q_pop            (q_pop),
    .inner_dim_cfg    (inner_dim_cfg),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_product_value(product_raw),
    .out_range_error  (out_range_error)
  );

  assign out_product_value = $signed(product_raw);

endmodule
